// File: sv/dwtq_pkg.sv
// Shared types, codes and constants for the delayed wakeup timer queue.
package dwtq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_WAKES    = 32;
    localparam int WAKE_W       = $clog2(MAX_WAKES + 1);
    localparam int TIME_W       = 32;
    localparam int TID_W        = 8;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_TIME     = 2'd1,
        OP_DELAY    = 2'd2,
        OP_DELAY_AT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_WAKE     = 2'd0,
        KIND_TIME     = 2'd1,
        KIND_TICK_ACK = 2'd2,
        KIND_FULL     = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic [TID_W-1:0]   requester_tid;
        logic [TIME_W-1:0]  amount;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [TID_W-1:0]   target_tid;
        logic [TIME_W-1:0]  tick_value;
        logic               last;
    } t_result;

    // One stored waiter.
    typedef struct packed {
        logic [TIME_W-1:0]  wake_time;
        logic [TID_W-1:0]   waiter_id;
    } t_entry;

    // Operands for the shared add/compare unit.
    typedef struct packed {
        logic [TIME_W-1:0]  a;
        logic [TID_W-1:0]   a_id;
        logic [TIME_W-1:0]  b;
        logic [TID_W-1:0]   b_id;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0]  sum;
        logic               later;  // (a, a_id) wakes strictly after (b, b_id)
        logic               le;     // a <= b
    } t_alu_rsp;

endpackage

// File: sv/dwtq_alu.sv
// Shared add and compare unit used by the queue sequencer.
module dwtq_alu (
    input  dwtq_pkg::t_alu_req i_req,
    output dwtq_pkg::t_alu_rsp o_rsp
);

    logic w_gt;
    logic w_eq;

    assign w_gt = i_req.a > i_req.b;
    assign w_eq = i_req.a == i_req.b;

    assign o_rsp.sum   = i_req.a + i_req.b;
    assign o_rsp.later = w_gt | (w_eq & (i_req.a_id > i_req.b_id));
    assign o_rsp.le    = ~w_gt;

endmodule

// File: sv/dwtq_store.sv
// Waiter store: one write port and one registered read port.
module dwtq_store #(
    parameter int CAPACITY = dwtq_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  dwtq_pkg::t_entry            i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    output dwtq_pkg::t_entry            o_rd_data
);

    dwtq_pkg::t_entry r_mem [CAPACITY];
    dwtq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/delayed_wakeup_timer_queue.sv
// Top level: tick counter, sorted waiter ring and the sequencer that drives it.
// A time query, or a delay made while the store is full, is answered from idle: its
// result is registered and appears in the cycle after the accept; busy stays low. A delay
// holds busy while it forms the wake time and walks back from the tail, moving each stored
// waiter that wakes after the new one up a slot, until it finds its place or reaches the
// front. A tick holds busy while it updates the counter and then wakes due waiters from the
// front, one read and compare each, until one is not due, the store runs empty or 32 have
// woken; its acknowledge is shown in the first cycle with busy low. The walks are paced by
// the store, whose single read port is registered, and by the single comparator walking the
// store one entry per step. Results come at most one per cycle and are shown for exactly one
// cycle, with o_valid high; the receiver cannot stall them, so it must take every beat when
// o_valid is high.
module delayed_wakeup_timer_queue #(
    parameter int CAPACITY = dwtq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  dwtq_pkg::t_cmd     i_cmd,
    output logic               o_busy,
    output logic               o_valid,
    output dwtq_pkg::t_result  o_result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_INS_RD,
        S_INS_CMP,
        S_POP_RD,
        S_POP_CMP
    } t_state;

    t_state                          r_state, n_state;
    logic [dwtq_pkg::TIME_W-1:0]     r_tick, n_tick;
    logic [IDX_W-1:0]                r_head, n_head;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [IDX_W-1:0]                r_pos, n_pos;
    logic [CNT_W-1:0]                r_left, n_left;
    logic [dwtq_pkg::WAKE_W-1:0]     r_woken, n_woken;
    dwtq_pkg::t_cmd                  r_cmd, n_cmd;
    logic [dwtq_pkg::TIME_W-1:0]     r_time, n_time;
    logic                            r_valid, n_valid;
    dwtq_pkg::t_result               r_result, n_result;

    logic                            w_accept;
    logic [CNT_W:0]                  w_tail_sum;
    logic [IDX_W-1:0]                w_tail;
    logic [IDX_W-1:0]                w_pos_prev;
    logic [IDX_W-1:0]                w_head_next;
    dwtq_pkg::t_alu_req              w_alu_req;
    dwtq_pkg::t_alu_rsp              w_alu_rsp;
    logic                            w_wr_en;
    logic [IDX_W-1:0]                w_wr_addr;
    dwtq_pkg::t_entry                w_wr_data;
    logic                            w_rd_en;
    logic [IDX_W-1:0]                w_rd_addr;
    dwtq_pkg::t_entry                w_rd_data;

    dwtq_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    dwtq_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_tail_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, r_head} + {1'b0, r_count};
    assign w_tail      = (w_tail_sum >= (CNT_W + 1)'(CAPACITY))
                         ? IDX_W'(w_tail_sum - (CNT_W + 1)'(CAPACITY))
                         : IDX_W'(w_tail_sum);
    assign w_pos_prev  = (r_pos == '0) ? LAST_IDX : r_pos - 1'b1;
    assign w_head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;

    // Operand steering for the shared unit.
    always_comb begin
        w_alu_req      = '0;
        w_alu_req.a    = w_rd_data.wake_time;
        w_alu_req.a_id = w_rd_data.waiter_id;
        case (r_state)
            S_ADD: begin
                w_alu_req.a    = r_tick;
                w_alu_req.a_id = '0;
                w_alu_req.b    = (r_cmd.op == dwtq_pkg::OP_TICK)
                                 ? dwtq_pkg::TIME_W'(1) : r_cmd.amount;
            end
            S_INS_CMP: begin
                w_alu_req.b    = r_time;
                w_alu_req.b_id = r_cmd.requester_tid;
            end
            S_POP_CMP: begin
                w_alu_req.b    = r_tick;
            end
            default: begin
                w_alu_req.b    = r_tick;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_tick    = r_tick;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_left    = r_left;
        n_woken   = r_woken;
        n_cmd     = r_cmd;
        n_time    = r_time;
        n_valid   = 1'b0;
        n_result  = r_result;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = '{wake_time: r_time, waiter_id: r_cmd.requester_tid};
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        dwtq_pkg::OP_TICK: begin
                            n_state = S_ADD;
                        end
                        dwtq_pkg::OP_TIME: begin
                            n_valid  = 1'b1;
                            n_result = '{kind: dwtq_pkg::KIND_TIME,
                                         target_tid: i_cmd.requester_tid,
                                         tick_value: r_tick, last: 1'b1};
                        end
                        default: begin
                            if (r_count == FULL_CNT) begin
                                n_valid  = 1'b1;
                                n_result = '{kind: dwtq_pkg::KIND_FULL,
                                             target_tid: i_cmd.requester_tid,
                                             tick_value: r_tick, last: 1'b1};
                            end else begin
                                n_state = S_ADD;
                            end
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (r_cmd.op == dwtq_pkg::OP_TICK) begin
                    n_tick  = w_alu_rsp.sum;
                    n_woken = '0;
                    n_state = S_POP_RD;
                end else begin
                    n_time  = (r_cmd.op == dwtq_pkg::OP_DELAY) ? w_alu_rsp.sum
                                                               : r_cmd.amount;
                    n_pos   = w_tail;
                    n_left  = r_count;
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (r_left == '0) begin
                    // Reached the front: place the new waiter here.
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_pos_prev;
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_wr_en = 1'b1;
                if (w_alu_rsp.later) begin
                    // Move the later waiter up one slot and keep walking back.
                    w_wr_data = w_rd_data;
                    n_pos     = w_pos_prev;
                    n_left    = r_left - 1'b1;
                    n_state   = S_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POP_RD: begin
                if ((r_count == '0) || (r_woken == dwtq_pkg::WAKE_W'(dwtq_pkg::MAX_WAKES))) begin
                    n_valid  = 1'b1;
                    n_result = '{kind: dwtq_pkg::KIND_TICK_ACK, target_tid: '0,
                                 tick_value: r_tick, last: 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_POP_CMP;
                end
            end
            S_POP_CMP: begin
                n_valid = 1'b1;
                if (w_alu_rsp.le) begin
                    n_result = '{kind: dwtq_pkg::KIND_WAKE,
                                 target_tid: w_rd_data.waiter_id,
                                 tick_value: r_tick, last: 1'b0};
                    n_head   = w_head_next;
                    n_count  = r_count - 1'b1;
                    n_woken  = r_woken + 1'b1;
                    n_state  = S_POP_RD;
                end else begin
                    n_result = '{kind: dwtq_pkg::KIND_TICK_ACK, target_tid: '0,
                                 tick_value: r_tick, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_pos    <= n_pos;
        r_left   <= n_left;
        r_woken  <= n_woken;
        r_cmd    <= n_cmd;
        r_time   <= n_time;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("waiter count above capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_IDX)
        else $error("head pointer out of range");

    a_wake_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.kind == dwtq_pkg::KIND_WAKE)) |-> !o_result.last)
        else $error("wake beat marked last");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.op == dwtq_pkg::OP_TICK)) |=> (o_busy && !o_valid))
        else $error("tick not taken into the sequencer");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> !o_busy)
        else $error("final beat while still busy");

endmodule

// File: test/dwtq_checker.sv
// Checker for the delayed wakeup timer queue: predicts every result beat and compares.
`timescale 1ns / 1ps

module dwtq_checker #(
    parameter int CAPACITY = dwtq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  dwtq_pkg::t_cmd     i_cmd,
    input  logic               i_valid,
    input  dwtq_pkg::t_result  i_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [dwtq_pkg::TIME_W-1:0]  tick_now;
    dwtq_pkg::t_entry             waiters[$];     // kept in wake order
    dwtq_pkg::t_result            due_replies[$];
    int                           fails;

    task automatic report_mismatch(input string msg);
        fails++;
        $display("dwtq_checker: %0t: %s", $realtime, msg);
    endtask

    // Order of wakeup: earlier time first, then lower id.
    function automatic bit wakes_after(dwtq_pkg::t_entry a, dwtq_pkg::t_entry b);
        if (a.wake_time != b.wake_time) return a.wake_time > b.wake_time;
        return a.waiter_id > b.waiter_id;
    endfunction

    task automatic add_reply(input dwtq_pkg::t_kind kind,
                             input logic [dwtq_pkg::TID_W-1:0] tid, input logic last);
        dwtq_pkg::t_result r;
        r.kind       = kind;
        r.target_tid = tid;
        r.tick_value = tick_now;
        r.last       = last;
        due_replies.push_back(r);
    endtask

    task automatic predict_replies(input dwtq_pkg::t_cmd cmd);
        dwtq_pkg::t_entry e;
        int               pos;
        int               woken;
        case (cmd.op)
            dwtq_pkg::OP_TICK: begin
                tick_now = tick_now + 1'b1;
                woken = 0;
                while (woken < dwtq_pkg::MAX_WAKES && waiters.size() > 0
                       && waiters[0].wake_time <= tick_now) begin
                    add_reply(dwtq_pkg::KIND_WAKE, waiters[0].waiter_id, 1'b0);
                    void'(waiters.pop_front());
                    woken++;
                end
                add_reply(dwtq_pkg::KIND_TICK_ACK, '0, 1'b1);
            end
            dwtq_pkg::OP_TIME: begin
                add_reply(dwtq_pkg::KIND_TIME, cmd.requester_tid, 1'b1);
            end
            default: begin
                if (waiters.size() >= CAPACITY) begin
                    add_reply(dwtq_pkg::KIND_FULL, cmd.requester_tid, 1'b1);
                end else begin
                    e.wake_time = (cmd.op == dwtq_pkg::OP_DELAY) ? tick_now + cmd.amount
                                                                 : cmd.amount;
                    e.waiter_id = cmd.requester_tid;
                    // equal entries keep arrival order: stop at the first one not later
                    pos = waiters.size();
                    while (pos > 0 && wakes_after(waiters[pos-1], e)) pos--;
                    waiters.insert(pos, e);
                end
            end
        endcase
    endtask

    task automatic check_reply(input dwtq_pkg::t_result got);
        dwtq_pkg::t_result want;
        if (due_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind=%0d tid=%0d tick=%0d last=%0d",
                                      got.kind, got.target_tid, got.tick_value, got.last));
            return;
        end
        want = due_replies.pop_front();
        if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.target_tid != want.target_tid)
            report_mismatch($sformatf("target_tid %0d, expected %0d",
                                      got.target_tid, want.target_tid));
        if (got.tick_value != want.tick_value)
            report_mismatch($sformatf("tick_value %0d, expected %0d",
                                      got.tick_value, want.tick_value));
        if (got.last != want.last)
            report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_now = '0;
            waiters.delete();
            due_replies.delete();
            fails   = 0;
        end else begin
            // a result beat at this edge always belongs to an earlier command
            if (i_valid) check_reply(i_result);
            if (i_start && !i_busy) predict_replies(i_cmd);
        end
        o_fail_count <= fails;
        o_pending    <= due_replies.size();
    end

endmodule

// File: test/tb_top.sv
// Testbench top for the delayed wakeup timer queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY   = dwtq_pkg::CAPACITY_DEF;
    localparam int DRAIN      = 2 * CAPACITY + 8;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_start;
    dwtq_pkg::t_cmd     i_cmd;
    logic               o_busy;
    logic               o_valid;
    dwtq_pkg::t_result  o_result;

    int                           fail_count;
    int                           pending;
    int                           cycle_count = 0;
    int                           gap_max;
    logic [dwtq_pkg::TIME_W-1:0]  tick_seen;

    delayed_wakeup_timer_queue #(.CAPACITY(CAPACITY)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    dwtq_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Send one command beat; returns, with start still high, once it is taken and busy is low.
    task automatic send_cmd(input dwtq_pkg::t_op op, input logic [dwtq_pkg::TID_W-1:0] tid,
                            input logic [dwtq_pkg::TIME_W-1:0] amt);
        dwtq_pkg::t_cmd cmd;
        int             gap;
        cmd.op            = op;
        cmd.requester_tid = tid;
        cmd.amount        = amt;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= cmd;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (op == dwtq_pkg::OP_TICK) tick_seen = tick_seen + 1'b1;
    endtask

    // Hold off until every outstanding result beat has come back.
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mostly wake times near the counter so waiters keep draining; a few far ones.
    function automatic logic [dwtq_pkg::TIME_W-1:0] pick_amount(input dwtq_pkg::t_op op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return $urandom;
        if (op == dwtq_pkg::OP_DELAY) begin
            if (r < 20) return 32'd0 - $urandom_range(1, 4);  // wraps to an already due time
            return $urandom_range(0, 6);
        end
        if (r < 25) return $urandom_range(0, tick_seen);
        return tick_seen + $urandom_range(0, 6);
    endfunction

    initial begin
        int            r;
        int            tid;
        dwtq_pkg::t_op op;

        i_rst_n   = 1'b0;
        i_start   = 1'b0;
        i_cmd     = '0;
        tick_seen = '0;
        gap_max   = 16;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every op, ties and wrapping delay
        send_cmd(dwtq_pkg::OP_TIME, 8'd0, 32'd0);
        send_cmd(dwtq_pkg::OP_TICK, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(dwtq_pkg::OP_DELAY, 8'hFF, 32'd0);
        send_cmd(dwtq_pkg::OP_DELAY_AT, 8'd0, 32'd0);
        send_cmd(dwtq_pkg::OP_DELAY, 8'd3, 32'hFFFF_FFFF);
        send_cmd(dwtq_pkg::OP_DELAY_AT, 8'd10, 32'd3);
        send_cmd(dwtq_pkg::OP_DELAY_AT, 8'd9, 32'd3);
        send_cmd(dwtq_pkg::OP_DELAY_AT, 8'd9, 32'd3);
        send_cmd(dwtq_pkg::OP_TIME, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(dwtq_pkg::OP_TICK, 8'd0, 32'd0);
        send_cmd(dwtq_pkg::OP_TICK, 8'd0, 32'd0);
        send_cmd(dwtq_pkg::OP_TICK, 8'd0, 32'd0);

        // fill the store back to back, overflow it, then wake everything in one tick
        wait_idle();
        gap_max = 0;
        repeat (CAPACITY + 2)
            send_cmd(dwtq_pkg::OP_DELAY_AT, dwtq_pkg::TID_W'($urandom_range(0, 255)),
                     tick_seen + 1'b1);
        wait_idle();
        send_cmd(dwtq_pkg::OP_TICK, 8'd0, 32'd0);

        // second fill with spread wake times and many equal ids
        gap_max = 16;
        repeat (CAPACITY + 2)
            send_cmd(dwtq_pkg::OP_DELAY, dwtq_pkg::TID_W'($urandom_range(0, 3)),
                     $urandom_range(1, 4));
        repeat (5)
            send_cmd(dwtq_pkg::OP_TICK, dwtq_pkg::TID_W'($urandom_range(0, 255)), $urandom);

        for (int n = 0; n < 170; n++) begin
            if (n % 25 == 0) gap_max = ($urandom_range(0, 1) == 0) ? 0 : 16;
            r   = $urandom_range(0, 99);
            tid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
            if (r < 30) op = dwtq_pkg::OP_TICK;
            else if (r < 40) op = dwtq_pkg::OP_TIME;
            else if (r < 70) op = dwtq_pkg::OP_DELAY;
            else op = dwtq_pkg::OP_DELAY_AT;
            send_cmd(op, dwtq_pkg::TID_W'(tid), pick_amount(op));
        end

        wait_idle();
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
